>>> sv/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ede_pkg.sv
package ede_pkg;

	localparam int VAL_PORT_W = 32;
	localparam int BYTE_W     = 8;
	localparam int PEND_W     = 7;
	localparam int VB_W       = 4;
	localparam int FIFO_DEPTH = 2;

	typedef enum logic {
		PK_IDLE,
		PK_EMIT
	} pk_state_t;

	// per-item control carried from front to packer
	typedef struct packed {
		logic flush;
		logic zero;
	} ede_ctl_t;

	// value bits that can be nonzero
	function automatic int ede_iw(input int vw);
		return (vw < VAL_PORT_W) ? vw : VAL_PORT_W;
	endfunction

	function automatic int ede_nw(input int vw);
		return $clog2(ede_iw(vw));
	endfunction

	// longest code: 2L+1+N with L <= NW, N < IW
	function automatic int ede_len_max(input int vw);
		return 2 * ede_nw(vw) + ede_iw(vw);
	endfunction

	function automatic int ede_len_w(input int vw);
		return $clog2(ede_len_max(vw) + 1);
	endfunction

endpackage

>>> sv/ede_front.sv
module ede_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          push,
	output logic                                          full,
	input  logic [ede_pkg::VAL_PORT_W-1:0]                value,
	input  logic                                          flush,
	input  logic                                          q_full,
	output logic                                          q_push,
	output logic [ede_pkg::ede_len_max(VALUE_WIDTH)-1:0]  q_code,
	output logic [ede_pkg::ede_len_w(VALUE_WIDTH)-1:0]    q_len,
	output ede_pkg::ede_ctl_t                             q_ctl
);

	localparam int IW      = ede_pkg::ede_iw(VALUE_WIDTH);
	localparam int NW      = ede_pkg::ede_nw(VALUE_WIDTH);
	localparam int LEN_MAX = ede_pkg::ede_len_max(VALUE_WIDTH);
	localparam int LEN_W   = ede_pkg::ede_len_w(VALUE_WIDTH);
	localparam int LW      = $clog2(NW + 1);

	logic                 v_s1, v_s2;
	logic [IW-1:0]        value_s1;
	logic                 flush_s1;
	logic [LEN_MAX-1:0]   code_s2;
	logic [LEN_W-1:0]     len_s2;
	ede_pkg::ede_ctl_t    ctl_s2;

	logic                 go_s1, go_s2, free_s2;
	logic [NW-1:0]        n;
	logic [NW:0]          np1;
	logic [LW-1:0]        l;
	logic                 zero;
	logic [IW-1:0]        low;
	logic [LEN_MAX-1:0]   code_r;
	logic [LEN_W-1:0]     len;

	assign go_s2   = v_s2 & ~q_full;
	assign free_s2 = ~v_s2 | go_s2;
	assign go_s1   = v_s1 & free_s2;
	assign full    = v_s1 & ~go_s1;
	assign q_push  = go_s2;

	// leading-one positions of the value (N) and of N+1 (L), then code and length
	always_comb begin
		n = '0;
		for (int i = 0; i < IW; i++) begin
			if (value_s1[i]) n = NW'(i);
		end
		np1 = {1'b0, n} + (NW + 1)'(1);
		l = '0;
		for (int i = 0; i <= NW; i++) begin
			if (np1[i]) l = LW'(i);
		end
		zero = (value_s1 == '0);
		low  = value_s1 ^ (IW'(1) << n);
		if (zero) begin
			code_r = '0;
			len    = '0;
		end else begin
			code_r = (LEN_MAX'(np1) << n) | LEN_MAX'(low);
			len    = LEN_W'({l, 1'b1}) + LEN_W'(n);
		end
	end

	// left-align the code word for the packer
	assign q_code = code_s2 << (LEN_W'(LEN_MAX) - len_s2);
	assign q_len  = len_s2;
	assign q_ctl  = ctl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (push && !full) v_s1 <= 1'b1;
			else if (go_s1) v_s1 <= 1'b0;
			if (go_s1) v_s2 <= 1'b1;
			else if (go_s2) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			value_s1 <= value[IW-1:0];
			flush_s1 <= flush;
		end
		if (go_s1) begin
			code_s2      <= code_r;
			len_s2       <= len;
			ctl_s2.flush <= flush_s1;
			ctl_s2.zero  <= zero;
		end
	end

endmodule

>>> sv/ede_fifo.sv
module ede_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] dout,
	output logic          empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

endmodule

>>> sv/ede_back.sv
module ede_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          q_empty,
	output logic                                          q_pop,
	input  logic [ede_pkg::ede_len_max(VALUE_WIDTH)-1:0]  q_code,
	input  logic [ede_pkg::ede_len_w(VALUE_WIDTH)-1:0]    q_len,
	input  ede_pkg::ede_ctl_t                             q_ctl,
	output logic                                          empty,
	input  logic                                          pop,
	output logic [ede_pkg::BYTE_W-1:0]                    code_byte,
	output logic [ede_pkg::VB_W-1:0]                      valid_bits,
	output logic                                          run_last,
	output logic                                          stream_end,
	output logic                                          zero_error
);

	localparam int LEN_MAX = ede_pkg::ede_len_max(VALUE_WIDTH);
	localparam int WW      = LEN_MAX + ede_pkg::PEND_W;
	localparam int CW      = $clog2(WW + 1);
	localparam int BW      = ede_pkg::BYTE_W;

	ede_pkg::pk_state_t state_q, state_d;

	// left-aligned bit window; bits below cnt_q are zero
	logic [WW-1:0]   w_q, w_n, w_ld;
	logic [CW-1:0]   cnt_q, cnt_n, cnt_ld;
	logic            err_q, err_n, fl_q;

	logic                          ov_q;
	logic [BW-1:0]                 byte_q, r_byte;
	logic [ede_pkg::VB_W-1:0]      vb_q, r_vb;
	logic                          last_q, end_q, zerr_q;
	logic                          r_last, r_end, r_zerr;
	logic                          any, ostall, load, emit_go;

	assign any    = err_q | (cnt_q >= CW'(BW)) | (fl_q & (cnt_q != '0));
	assign ostall = ov_q & ~pop;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ede_pkg::PK_IDLE: begin
				if (!q_empty) state_d = ede_pkg::PK_EMIT;
			end
			ede_pkg::PK_EMIT: begin
				if (!any || (emit_go && r_last)) state_d = ede_pkg::PK_IDLE;
			end
			default: state_d = ede_pkg::PK_IDLE;
		endcase
	end

	always_comb begin
		load    = (state_q == ede_pkg::PK_IDLE) & ~q_empty;
		emit_go = (state_q == ede_pkg::PK_EMIT) & any & ~ostall;
		q_pop   = load;

		w_ld   = w_q | ({q_code, ede_pkg::PEND_W'(0)} >> cnt_q);
		cnt_ld = cnt_q + CW'(q_len);

		err_n  = 1'b0;
		r_zerr = 1'b0;
		r_byte = w_q[WW-1 -: BW];
		if (err_q) begin
			r_byte = '0;
			r_vb   = '0;
			r_zerr = 1'b1;
			w_n    = w_q;
			cnt_n  = cnt_q;
		end else if (cnt_q >= CW'(BW)) begin
			r_vb  = ede_pkg::VB_W'(BW);
			w_n   = w_q << BW;
			cnt_n = cnt_q - CW'(BW);
		end else begin
			// flushed partial byte, already zero-padded
			r_vb  = cnt_q[ede_pkg::VB_W-1:0];
			w_n   = '0;
			cnt_n = '0;
		end
		r_last = ~(err_n | (cnt_n >= CW'(BW)) | (fl_q & (cnt_n != '0)));
		r_end  = fl_q & r_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ede_pkg::PK_IDLE;
			w_q     <= '0;
			cnt_q   <= '0;
			err_q   <= 1'b0;
			fl_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				w_q   <= w_ld;
				cnt_q <= cnt_ld;
				err_q <= q_ctl.zero;
				fl_q  <= q_ctl.flush;
			end else if (emit_go) begin
				w_q   <= w_n;
				cnt_q <= cnt_n;
				err_q <= err_n;
			end
			if (emit_go) ov_q <= 1'b1;
			else if (pop) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			byte_q <= r_byte;
			vb_q   <= r_vb;
			last_q <= r_last;
			end_q  <= r_end;
			zerr_q <= r_zerr;
		end
	end

	assign empty      = ~ov_q;
	assign code_byte  = byte_q;
	assign valid_bits = vb_q;
	assign run_last   = last_q;
	assign stream_end = end_q;
	assign zero_error = zerr_q;

endmodule

>>> sv/elias_delta_encoder.sv
// Elias delta encoder with an MSB-first byte packer.
// Input channel: push/full queue. One beat carries value (32 bits, only the
//   low VALUE_WIDTH bits are used) and flush, which marks the last value.
// Result channel: empty/pop queue. Each beat carries one byte of the code
//   stream (first bit in bit 7), valid_bits (8 for a full byte, 1..7 for the
//   flushed tail, 0 for an error beat), run_last on the final beat caused by
//   an input beat, stream_end on the final beat after a flush, and zero_error
//   when the value was zero (no bits encoded).
// Structure: a two-stage front (leading-one search and code build, then left
//   alignment) feeds a two-entry queue; the packer behind it merges the code
//   into up to seven pending bits and sends bytes one per cycle unless held.
// Path: an accepted input beat goes through the front's stages, the queue,
//   the packer's bit window and the result register.
// Flow: the packer loads one item, then sends its result beats one at a time,
//   or makes one check when the item yields none, and only then loads the
//   next; the packer has a single byte output.
// Reset: pending bits cleared, queue and result register empty.
// Stall: a held result stays on the ports; the queue and the front keep
//   taking beats until they fill, then full rises.
module elias_delta_encoder #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [ede_pkg::VAL_PORT_W-1:0] value,
	input  logic                           flush,
	output logic                           empty,
	input  logic                           pop,
	output logic [ede_pkg::BYTE_W-1:0]     code_byte,
	output logic [ede_pkg::VB_W-1:0]       valid_bits,
	output logic                           run_last,
	output logic                           stream_end,
	output logic                           zero_error
);

	localparam int LEN_MAX = ede_pkg::ede_len_max(VALUE_WIDTH);
	localparam int LEN_W   = ede_pkg::ede_len_w(VALUE_WIDTH);
	localparam int CTL_W   = $bits(ede_pkg::ede_ctl_t);
	localparam int DW      = LEN_MAX + LEN_W + CTL_W;

	// front -> queue
	logic               f_push, q_full;
	logic [LEN_MAX-1:0] f_code;
	logic [LEN_W-1:0]   f_len;
	ede_pkg::ede_ctl_t  f_ctl;

	// queue -> packer
	logic               q_empty, q_pop;
	logic [DW-1:0]      q_dout;
	logic [LEN_MAX-1:0] b_code;
	logic [LEN_W-1:0]   b_len;
	ede_pkg::ede_ctl_t  b_ctl;

	ede_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.value  (value),
		.flush  (flush),
		.q_full (q_full),
		.q_push (f_push),
		.q_code (f_code),
		.q_len  (f_len),
		.q_ctl  (f_ctl)
	);

	ede_fifo #(.DW(DW), .DEPTH(ede_pkg::FIFO_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    ({f_code, f_len, f_ctl}),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign {b_code, b_len, b_ctl} = q_dout;

	ede_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_code     (b_code),
		.q_len      (b_len),
		.q_ctl      (b_ctl),
		.empty      (empty),
		.pop        (pop),
		.code_byte  (code_byte),
		.valid_bits (valid_bits),
		.run_last   (run_last),
		.stream_end (stream_end),
		.zero_error (zero_error)
	);

endmodule

>>> sv/ede_checker.sv
`include "assert_macros.svh"

module ede_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       empty,
	input logic                       pop,
	input logic [ede_pkg::BYTE_W-1:0] code_byte,
	input logic [ede_pkg::VB_W-1:0]   valid_bits,
	input logic                       run_last,
	input logic                       stream_end,
	input logic                       zero_error
);

	// stream end always closes the item's run
	`ASSERT_ALWAYS(a_end_last, clk, arst_n, empty || !stream_end || run_last, "stream_end without run_last")

	// error beat carries no bits
	`ASSERT_ALWAYS(a_err_nobits, clk, arst_n, empty || !zero_error || (valid_bits == '0 && code_byte == '0), "error beat with bits")

	// data beat: 1..8 bits, short only on the flushed tail
	`ASSERT_ALWAYS(a_vb_range, clk, arst_n, empty || zero_error || (valid_bits != '0 && (valid_bits == ede_pkg::VB_W'(ede_pkg::BYTE_W) || stream_end)), "bad valid_bits")

	// held result does not change
	`ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(code_byte) && $stable(valid_bits), "result changed while held")

endmodule

bind elias_delta_encoder ede_checker u_ede_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.code_byte  (code_byte),
	.valid_bits (valid_bits),
	.run_last   (run_last),
	.stream_end (stream_end),
	.zero_error (zero_error)
);

>>> bench/elias_delta_encoder_test.sv
`timescale 1ns / 1ps

// Bench for the Elias delta encoder. Values go in on the push/full side; the
// packed code bytes come out on the empty/pop side. A local bit packer
// mirrors the block, so every accepted value queues the beats it should
// produce. Each popped beat is checked field by field against the oldest of
// them.
module elias_delta_encoder_test;

	// One result beat as seen on the output ports.
	typedef struct {
		logic [ede_pkg::BYTE_W-1:0] code_byte;
		logic [ede_pkg::VB_W-1:0]   valid_bits;
		logic                       run_last;
		logic                       stream_end;
		logic                       zero_error;
	} code_beat_t;

	// Worst case is about 350 values x 7 beats x the longest pop stall, plus the
	// sender gaps; this is several times that.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_VALUES = 320;
	localparam int DRAIN_CYCLES = 8;   // lets the pipe drain, with margin
	localparam int MAX_REPORTS = 40;

	logic                           clk;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	logic [ede_pkg::VAL_PORT_W-1:0] value;
	logic                           flush;
	logic                           empty;
	logic                           pop;
	logic [ede_pkg::BYTE_W-1:0]     code_byte;
	logic [ede_pkg::VB_W-1:0]       valid_bits;
	logic                           run_last;
	logic                           stream_end;
	logic                           zero_error;

	// Packer mirror: up to seven bits not yet sent, right-aligned.
	logic [7:0] pack_acc;
	int         pack_cnt;

	code_beat_t code_beat_q[$];   // beats still owed by the block
	int         fail_count;
	int         cycle_count;
	bit         src_steady;       // no sender gaps while set
	bit         snk_steady;       // no pop stalls while set
	int         snk_hold;

	elias_delta_encoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value      (value),
		.flush      (flush),
		.empty      (empty),
		.pop        (pop),
		.code_byte  (code_byte),
		.valid_bits (valid_bits),
		.run_last   (run_last),
		.stream_end (stream_end),
		.zero_error (zero_error)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Mostly no gap or a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Random value: a random bit length so short and long codes both show
	// up often, plus an occasional zero to hit the error path.
	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		int          w;
		if ($urandom_range(0, 99) < 4)
			return '0;
		w = $urandom_range(1, 32);
		v = $urandom;
		if (w < 32)
			v = v & ((32'd1 << w) - 32'd1);
		v[w-1] = 1'b1;
		return v;
	endfunction

	// Shift one code bit into the packer mirror; a full byte is owed at once.
	task automatic pack_bit(input logic b, ref code_beat_t beats[$]);
		code_beat_t cb;
		pack_acc = {pack_acc[6:0], b};
		pack_cnt++;
		if (pack_cnt == 8) begin
			cb.code_byte  = pack_acc;
			cb.valid_bits = 4'd8;
			cb.run_last   = 1'b0;
			cb.stream_end = 1'b0;
			cb.zero_error = 1'b0;
			beats.push_back(cb);
			pack_acc = '0;
			pack_cnt = 0;
		end
	endtask

	// Predict the beats for one accepted value.
	// Code: L zeros, N+1 in L+1 bits, then the N bits under the leading one,
	// with N = floor(log2 v) and L = floor(log2(N+1)).
	task automatic delta_encode(input logic [31:0] v, input logic f);
		code_beat_t beats[$];
		code_beat_t cb;
		int         n;
		int         l;
		int         i;
		cb.code_byte  = '0;
		cb.valid_bits = '0;
		cb.run_last   = 1'b0;
		cb.stream_end = 1'b0;
		cb.zero_error = 1'b0;
		if (v == '0) begin
			// zero: one error beat, nothing appended
			cb.zero_error = 1'b1;
			beats.push_back(cb);
		end else begin
			n = 0;
			for (i = 31; i >= 0; i--) begin
				if (v[i]) begin
					n = i;
					break;
				end
			end
			l = 0;
			for (i = n + 1; i > 1; i = i >> 1)
				l++;
			for (i = 0; i < l; i++)
				pack_bit(1'b0, beats);
			for (i = l; i >= 0; i--)
				pack_bit(1'(((n + 1) >> i) & 1), beats);
			for (i = n - 1; i >= 0; i--)
				pack_bit(v[i], beats);
		end
		if (f) begin
			// tail byte only if bits are left; a byte-aligned end sends none
			if (pack_cnt > 0) begin
				cb.code_byte  = pack_acc << (8 - pack_cnt);
				cb.valid_bits = pack_cnt[ede_pkg::VB_W-1:0];
				cb.zero_error = 1'b0;
				beats.push_back(cb);
			end
			pack_acc = '0;
			pack_cnt = 0;
			if (beats.size() > 0)
				beats[$].stream_end = 1'b1;
		end
		if (beats.size() > 0)
			beats[$].run_last = 1'b1;
		foreach (beats[i])
			code_beat_q.push_back(beats[i]);
	endtask

	// Called at a falling edge; holds the beat until the block takes it.
	// push stays high into the next call unless a gap is drawn.
	task automatic send_value(input logic [31:0] v, input logic f);
		int g;
		push  <= 1'b1;
		value <= v;
		flush <= f;
		do
			@(posedge clk);
		while (full);
		delta_encode(v, f);
		@(negedge clk);
		g = src_steady ? 0 : gap_len();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	// Stop sending and wait until every owed beat has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		do
			@(negedge clk);
		while (code_beat_q.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
		end
	endtask

	// Result checker: every popped beat is matched against the oldest
	// prediction. Inputs settle at the falling edge, so the values read here
	// are the ones the block saw at this rising edge.
	always @(posedge clk) begin
		code_beat_t eb;
		if (arst_n && pop && !empty) begin
			if (code_beat_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$error("unexpected beat: code_byte %0h valid_bits %0d",
						code_byte, valid_bits);
			end else begin
				eb = code_beat_q.pop_front();
				check_field("code_byte", 32'(eb.code_byte), 32'(code_byte));
				check_field("valid_bits", 32'(eb.valid_bits), 32'(valid_bits));
				check_field("run_last", 32'(eb.run_last), 32'(run_last));
				check_field("stream_end", 32'(eb.stream_end), 32'(stream_end));
				check_field("zero_error", 32'(eb.zero_error), 32'(zero_error));
			end
		end
	end

	// Consumer: pops with random stalls, or every cycle while steady.
	initial begin
		pop = 1'b0;
		snk_hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (snk_hold > 0) begin
				pop <= 1'b0;
				snk_hold--;
			end else begin
				pop <= 1'b1;
				if (!snk_steady && $urandom_range(0, 3) == 0)
					snk_hold = gap_len();
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Code lengths at the edges of each L group, the extremes of the value
	// field, zero with and without pending bits, and flushes that end on a
	// byte boundary or leave a tail.
	task automatic test_directed();
		send_value(32'd1, 1'b1);            // 1-bit code, tail of 1
		send_value(32'd2, 1'b0);            // 4 bits
		send_value(32'd3, 1'b0);            // 4 bits, packer now byte aligned
		send_value(32'd4, 1'b0);
		send_value(32'd0, 1'b0);            // zero with bits pending
		send_value(32'd7, 1'b1);            // tail flush
		send_value(32'd8, 1'b1);            // 8-bit code: byte-aligned flush
		send_value(32'd0, 1'b1);            // zero, flush with nothing pending
		send_value(32'd15, 1'b0);
		send_value(32'd16, 1'b0);           // N steps to 4, L stays 2
		send_value(32'd0, 1'b1);            // zero, flush with bits pending
		send_value(32'd127, 1'b0);
		send_value(32'd128, 1'b0);          // L steps to 3
		send_value(32'h0000_8000, 1'b0);
		send_value(32'h0000_FFFF, 1'b1);    // L steps to 4 at N = 15
		send_value(32'h5555_5555, 1'b0);
		send_value(32'hAAAA_AAAA, 1'b0);
		send_value(32'h7FFF_FFFF, 1'b0);
		send_value(32'h8000_0000, 1'b0);
		send_value(32'hFFFF_FFFF, 1'b1);    // longest code
		send_value(32'd1, 1'b0);
		send_value(32'hFFFF_FFFF, 1'b1);
		wait_drained();
	endtask

	// Random values in blocks; every third block runs without any idling,
	// and halfway through the sender holds off until the block drains.
	task automatic test_random();
		int i;
		for (i = 0; i < RAND_VALUES; i++) begin
			src_steady = ((i / 40) % 3 == 2);
			snk_steady = src_steady;
			if (i == RAND_VALUES / 2)
				wait_drained();
			send_value(rand_value(), $urandom_range(0, 5) == 0);
		end
		src_steady = 1'b0;
		snk_steady = 1'b0;
		// close the stream so the last tail comes out too
		send_value(rand_value(), 1'b1);
		wait_drained();
	endtask

	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		value       = '0;
		flush       = 1'b0;
		pack_acc    = '0;
		pack_cnt    = 0;
		fail_count  = 0;
		cycle_count = 0;
		src_steady  = 1'b0;
		snk_steady  = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random();

		// nothing owed; give any stray beat time to show up
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
